// ===== src/lmls_pkg.sv =====
// ----------------------------------------------------------------------------
// lmls_pkg
// Shared types and constants for the lcd mode and line sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lmls_pkg;

    localparam int VISIBLE_LINES = 144;
    localparam int TOTAL_LINES   = 154;

    localparam int ACCUM_W = 11;
    localparam int THR_W   = 10;
    localparam int LINE_W  = 8;
    localparam int CFG_IDX_W = 2;

    // display modes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OAM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XFER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HBLANK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VBLANK = 2'd3;

    localparam logic [THR_W-1:0] OAM_RESET    = 10'd77;
    localparam logic [THR_W-1:0] XFER_RESET   = 10'd169;
    localparam logic [THR_W-1:0] HBLANK_RESET = 10'd201;
    localparam logic [THR_W-1:0] VBLANK_RESET = 10'd456;

    typedef struct packed {
        logic [THR_W-1:0] oam_cycles;
        logic [THR_W-1:0] transfer_cycles;
        logic [THR_W-1:0] hblank_cycles;
        logic [THR_W-1:0] vblank_line_cycles;
    } t_cfg;

    typedef struct packed {
        logic [7:0] cycles_elapsed;
        logic       lcd_on;
        logic [7:0] compare_line;
    } t_item;

    typedef struct packed {
        logic [1:0]        mode;
        logic [LINE_W-1:0] current_line;
        logic              coincidence;
        logic              render_line;
        logic              frame_wrap;
    } t_result;

endpackage

`default_nettype wire

// ===== src/lmls_if.sv =====
// ----------------------------------------------------------------------------
// lmls_if
// Valid/ready channels for timing items and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cycles_elapsed;
    logic       lcd_on;
    logic [7:0] compare_line;

    modport source (output valid, output cycles_elapsed, output lcd_on,
                    output compare_line, input ready);
    modport sink   (input valid, input cycles_elapsed, input lcd_on,
                    input compare_line, output ready);
endinterface

interface lmls_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] current_line;
    logic       coincidence;
    logic       render_line;
    logic       frame_wrap;

    modport source (output valid, output mode, output current_line,
                    output coincidence, output render_line, output frame_wrap,
                    input ready);
    modport sink   (input valid, input mode, input current_line,
                    input coincidence, input render_line, input frame_wrap,
                    output ready);
endinterface

`default_nettype wire

// ===== src/lcd_mode_line_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcd_mode_line_sequencer
// Four-mode display timer with line counter, stepped by elapsed-cycle items.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  i_in      in    valid/ready    cycles_elapsed, lcd_on, compare_line
//  o_out     out   valid/ready    mode, current_line, coincidence,
//                                 render_line, frame_wrap
//  i_cfg_*   in    write enable   register index, 10-bit threshold
//
//  one item per clock while no result is stalled; an item passes from the
//  input register through the step logic into the result register
//  the step logic and the timer state close one loop, so each item's
//  update is done before the next item reaches the step logic
//  synchronous active-low reset; timer restarts in OAM search at line 0
//  a stalled result holds its register; the input register fills once,
//  then the input stalls until the result transfers
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_mode_line_sequencer
    import lmls_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    lmls_in_if.sink                   i_in,
    lmls_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [THR_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_item   in_item, stage_item;
    t_result result;
    logic    stage_valid, take, in_ready, out_valid;

    assign in_item.cycles_elapsed = i_in.cycles_elapsed;
    assign in_item.lcd_on         = i_in.lcd_on;
    assign in_item.compare_line   = i_in.compare_line;

    lmls_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lmls_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .o_ready (in_ready),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    lmls_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (stage_valid),
        .i_item   (stage_item),
        .o_take   (take),
        .o_valid  (out_valid),
        .i_ready  (o_out.ready),
        .o_result (result)
    );

    assign i_in.ready         = in_ready;
    assign o_out.valid        = out_valid;
    assign o_out.mode         = result.mode;
    assign o_out.current_line = result.current_line;
    assign o_out.coincidence  = result.coincidence;
    assign o_out.render_line  = result.render_line;
    assign o_out.frame_wrap   = result.frame_wrap;

endmodule

`default_nettype wire

// ===== src/lmls_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lmls_cfg_regs
// Mode threshold registers behind the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lmls_cfg_regs
    import lmls_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [THR_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.oam_cycles         <= OAM_RESET;
            r_cfg.transfer_cycles    <= XFER_RESET;
            r_cfg.hblank_cycles      <= HBLANK_RESET;
            r_cfg.vblank_line_cycles <= VBLANK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OAM:    r_cfg.oam_cycles         <= i_cfg_data;
                REG_XFER:   r_cfg.transfer_cycles    <= i_cfg_data;
                REG_HBLANK: r_cfg.hblank_cycles      <= i_cfg_data;
                REG_VBLANK: r_cfg.vblank_line_cycles <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/lmls_in_stage.sv =====
// ----------------------------------------------------------------------------
// lmls_in_stage
// Input register; refills in the same cycle the core takes its item.
// ----------------------------------------------------------------------------
`default_nettype none

module lmls_in_stage
    import lmls_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_ready,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== src/lmls_core.sv =====
// ----------------------------------------------------------------------------
// lmls_core
// Mode timer state, single-pass step logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmls_core
    import lmls_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_take,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_result
);

    logic [ACCUM_W-1:0] r_accum, n_accum;
    logic [1:0]         r_mode, n_mode;
    logic [LINE_W-1:0]  r_line, n_line;
    logic               r_coin, n_coin;
    logic               r_out_valid;
    t_result            r_result;

    logic [ACCUM_W:0]   sum;
    logic [ACCUM_W-1:0] acc;
    logic [LINE_W:0]    line_inc;
    logic               line_end;
    logic [LINE_W-1:0]  line_next;
    logic               render, wrap;

    assign o_take = i_valid && (!r_out_valid || i_ready);

    assign sum       = {1'b0, r_accum} + {{(ACCUM_W+1-8){1'b0}}, i_item.cycles_elapsed};
    assign acc       = sum[ACCUM_W] ? {ACCUM_W{1'b1}} : sum[ACCUM_W-1:0];
    assign line_inc  = {1'b0, r_line} + {{LINE_W{1'b0}}, 1'b1};
    assign line_end  = line_inc >= (LINE_W+1)'(TOTAL_LINES);
    assign line_next = line_end ? '0 : line_inc[LINE_W-1:0];

    always_comb begin
        n_accum = acc;
        n_mode  = r_mode;
        n_line  = r_line;
        render  = 1'b0;
        wrap    = 1'b0;
        if (!i_item.lcd_on) begin
            n_mode = MODE_VBLANK;
        end else begin
            unique case (r_mode)
                MODE_HBLANK: begin
                    if (acc >= {1'b0, i_cfg.hblank_cycles}) begin
                        n_accum = '0;
                        n_line  = line_next;
                        wrap    = line_end;
                        // line_next is zero on wrap, so this also covers it
                        n_mode  = ({1'b0, line_next} >= (LINE_W+1)'(VISIBLE_LINES))
                                  ? MODE_VBLANK : MODE_OAM;
                    end
                end
                MODE_VBLANK: begin
                    if (acc >= {1'b0, i_cfg.vblank_line_cycles}) begin
                        n_accum = '0;
                        n_line  = line_next;
                        wrap    = line_end;
                        if (line_end) begin
                            n_mode = MODE_OAM;
                        end
                    end
                end
                MODE_OAM: begin
                    if (acc >= {1'b0, i_cfg.oam_cycles}) begin
                        n_accum = '0;
                        n_mode  = MODE_XFER;
                    end
                end
                MODE_XFER: begin
                    if (acc >= {1'b0, i_cfg.transfer_cycles}) begin
                        n_accum = '0;
                        render  = 1'b1;
                        n_mode  = MODE_HBLANK;
                    end
                end
                default: ;
            endcase
        end
        // flag held while the display is off
        n_coin = i_item.lcd_on ? (n_line == i_item.compare_line) : r_coin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_mode      <= MODE_OAM;
            r_line      <= '0;
            r_coin      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_accum <= n_accum;
                r_mode  <= n_mode;
                r_line  <= n_line;
                r_coin  <= n_coin;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result.mode         <= n_mode;
            r_result.current_line <= n_line;
            r_result.coincidence  <= n_coin;
            r_result.render_line  <= render;
            r_result.frame_wrap   <= wrap;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== src/lmls_checker.sv =====
// ----------------------------------------------------------------------------
// lmls_port_checks
// Port-level checks on the sequencer's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lmls_port_checks
    import lmls_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_mode,
    input wire logic [7:0] i_line,
    input wire logic       i_render,
    input wire logic       i_wrap
);

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // a stalled result stays put
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_mode) && $stable(i_line)
            && $stable(i_render) && $stable(i_wrap))
        else $error("stalled result changed");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_line < 8'(TOTAL_LINES))
        else $error("line counter out of range");

    // render ends transfer; wrap lands on line zero and never with render
    a_render_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_render |-> i_mode == MODE_HBLANK && !i_wrap)
        else $error("render strobe outside transfer end");

    a_wrap_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_wrap |-> i_line == 8'd0
            && (i_mode == MODE_OAM || i_mode == MODE_VBLANK))
        else $error("frame wrap with bad line or mode");

endmodule

bind lcd_mode_line_sequencer lmls_port_checks u_lmls_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_mode      (o_out.mode),
    .i_line      (o_out.current_line),
    .i_render    (o_out.render_line),
    .i_wrap      (o_out.frame_wrap)
);

`default_nettype wire

// ===== test/lmls_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lmls_checker
// Watches the item and result channels of the lcd mode and line sequencer,
// keeps its own copy of the display timer and the timing registers, and
// compares every result transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module lmls_checker
    import lmls_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    lmls_in_if                        i_in_mon,
    lmls_out_if                       i_out_mon,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [THR_W-1:0]     i_cfg_data,
    output logic [31:0]               o_fail_count,
    output logic [31:0]               o_outstanding
);

    localparam logic [ACCUM_W-1:0] ACCUM_MAX = '1;
    localparam int REPORT_LIMIT = 10;

    t_cfg               timing;
    logic [ACCUM_W-1:0] accum;
    logic [1:0]         mode_q;
    logic [LINE_W-1:0]  line_q;
    logic               coinc_q;
    t_result            timer_results[$];
    int unsigned        fail_count;

    // one step of the display timer, at most one mode change per item
    function automatic t_result step_timer(input t_item it);
        t_result           res;
        logic [ACCUM_W:0]  total;
        logic [LINE_W:0]   nxt;
        res   = '0;
        total = accum + it.cycles_elapsed;
        accum = (total > ACCUM_MAX) ? ACCUM_MAX : total[ACCUM_W-1:0];
        if (!it.lcd_on) begin
            mode_q = MODE_VBLANK;
        end else begin
            case (mode_q)
                MODE_HBLANK: begin
                    if (accum >= timing.hblank_cycles) begin
                        accum = '0;
                        nxt   = line_q + 1'b1;
                        if (nxt >= TOTAL_LINES) begin
                            nxt = '0;
                            res.frame_wrap = 1'b1;
                        end
                        line_q = nxt[LINE_W-1:0];
                        mode_q = (nxt >= VISIBLE_LINES) ? MODE_VBLANK : MODE_OAM;
                    end
                end
                MODE_VBLANK: begin
                    if (accum >= timing.vblank_line_cycles) begin
                        accum = '0;
                        nxt   = line_q + 1'b1;
                        if (nxt >= TOTAL_LINES) begin
                            nxt = '0;
                            res.frame_wrap = 1'b1;
                            mode_q = MODE_OAM;
                        end
                        line_q = nxt[LINE_W-1:0];
                    end
                end
                MODE_OAM: begin
                    if (accum >= timing.oam_cycles) begin
                        accum  = '0;
                        mode_q = MODE_XFER;
                    end
                end
                default: begin
                    if (accum >= timing.transfer_cycles) begin
                        accum  = '0;
                        res.render_line = 1'b1;
                        mode_q = MODE_HBLANK;
                    end
                end
            endcase
            coinc_q = (line_q == it.compare_line);
        end
        res.mode         = mode_q;
        res.current_line = line_q;
        res.coincidence  = coinc_q;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_item   it;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            timing.oam_cycles         = OAM_RESET;
            timing.transfer_cycles    = XFER_RESET;
            timing.hblank_cycles      = HBLANK_RESET;
            timing.vblank_line_cycles = VBLANK_RESET;
            accum      = '0;
            mode_q     = MODE_OAM;
            line_q     = '0;
            coinc_q    = 1'b0;
            fail_count = 0;
            timer_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OAM:    timing.oam_cycles         = i_cfg_data;
                    REG_XFER:   timing.transfer_cycles    = i_cfg_data;
                    REG_HBLANK: timing.hblank_cycles      = i_cfg_data;
                    REG_VBLANK: timing.vblank_line_cycles = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                it.cycles_elapsed = i_in_mon.cycles_elapsed;
                it.lcd_on         = i_in_mon.lcd_on;
                it.compare_line   = i_in_mon.compare_line;
                timer_results.push_back(step_timer(it));
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.mode         = i_out_mon.mode;
                got.current_line = i_out_mon.current_line;
                got.coincidence  = i_out_mon.coincidence;
                got.render_line  = i_out_mon.render_line;
                got.frame_wrap   = i_out_mon.frame_wrap;
                if (timer_results.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display({"unexpected result: mode %0d line %0d coin %0b ",
                                  "render %0b wrap %0b"},
                                 got.mode, got.current_line, got.coincidence,
                                 got.render_line, got.frame_wrap);
                    fail_count++;
                end else begin
                    want = timer_results.pop_front();
                    if (got.mode !== want.mode || got.current_line !== want.current_line ||
                        got.coincidence !== want.coincidence ||
                        got.render_line !== want.render_line ||
                        got.frame_wrap !== want.frame_wrap) begin
                        if (fail_count < REPORT_LIMIT) begin
                            $display({"mismatch exp: mode %0d line %0d coin %0b ",
                                      "render %0b wrap %0b"},
                                     want.mode, want.current_line, want.coincidence,
                                     want.render_line, want.frame_wrap);
                            $display({"         got: mode %0d line %0d coin %0b ",
                                      "render %0b wrap %0b"},
                                     got.mode, got.current_line, got.coincidence,
                                     got.render_line, got.frame_wrap);
                        end
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= timer_results.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives timing items into the lcd mode and line sequencer with random gaps,
// stalls its results at random, steps through several timing settings and
// leaves the checking to lmls_checker.
// ----------------------------------------------------------------------------
module tb_top
    import lmls_pkg::*;
();

    localparam int QUIET_LIMIT = 1000;
    localparam int MAX_WAIT    = 13;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [THR_W-1:0]     cfg_data;
    logic [31:0]          fail_count;
    logic [31:0]          outstanding;
    logic [LINE_W-1:0]    last_line;
    int unsigned          quiet_cycles;
    int unsigned          off_left;
    bit                   send_burst;
    bit                   recv_burst;

    lmls_in_if  in_ch();
    lmls_out_if out_ch();

    lcd_mode_line_sequencer u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lmls_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #2 clk = ~clk;

    function automatic int unsigned draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // last line seen on the result side, used to aim compare values
    always @(posedge clk) begin
        if (!rst_n) begin
            last_line <= '0;
        end else if (out_ch.valid && out_ch.ready) begin
            last_line <= out_ch.current_line;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall before each transfer
    initial begin
        int unsigned stall;
        out_ch.ready <= 1'b0;
        recv_burst = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            stall = draw_wait(recv_burst);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            if ($urandom_range(0, 29) == 0) recv_burst = ~recv_burst;
        end
    end

    task automatic push_item(input t_item it);
        int unsigned gap;
        gap = draw_wait(send_burst);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.cycles_elapsed <= it.cycles_elapsed;
        in_ch.lcd_on         <= it.lcd_on;
        in_ch.compare_line   <= it.compare_line;
        do @(posedge clk); while (!in_ch.ready);
        if ($urandom_range(0, 29) == 0) send_burst = ~send_burst;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic program_timings(input logic [THR_W-1:0] oam, input logic [THR_W-1:0] xfer,
                                   input logic [THR_W-1:0] hb, input logic [THR_W-1:0] vb);
        set_reg(REG_OAM, oam);
        set_reg(REG_XFER, xfer);
        set_reg(REG_HBLANK, hb);
        set_reg(REG_VBLANK, vb);
        cfg_we <= 1'b0;
    endtask

    function automatic t_item random_item();
        t_item       it;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            it.cycles_elapsed = 8'd0;
        else if (pick == 1)
            it.cycles_elapsed = 8'hFF;
        else if (pick < 5)
            it.cycles_elapsed = 8'($urandom_range(0, 15));
        else
            it.cycles_elapsed = 8'($urandom_range(0, 255));
        // display-off runs of varying length, landing on any mode
        if (off_left != 0) begin
            off_left--;
            it.lcd_on = 1'b0;
        end else if ($urandom_range(0, 39) == 0) begin
            off_left  = $urandom_range(0, 11);
            it.lcd_on = 1'b0;
        end else begin
            it.lcd_on = 1'b1;
        end
        pick = $urandom_range(0, 9);
        if (pick < 4)
            it.compare_line = last_line;
        else if (pick < 6)
            it.compare_line = last_line + 1'b1;
        else
            it.compare_line = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic run_items(input int unsigned count);
        repeat (count) push_item(random_item());
    endtask

    initial begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= REG_OAM;
        cfg_data             <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.cycles_elapsed <= '0;
        in_ch.lcd_on         <= 1'b0;
        in_ch.compare_line   <= '0;
        send_burst = 1'b0;
        off_left   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through one line with the timings left at reset
        push_item('{cycles_elapsed: 8'd0,   lcd_on: 1'b1, compare_line: 8'd0});
        push_item('{cycles_elapsed: 8'd76,  lcd_on: 1'b1, compare_line: 8'hFF});
        push_item('{cycles_elapsed: 8'd1,   lcd_on: 1'b1, compare_line: 8'd0});
        push_item('{cycles_elapsed: 8'hFF,  lcd_on: 1'b1, compare_line: 8'd0});
        push_item('{cycles_elapsed: 8'd200, lcd_on: 1'b1, compare_line: 8'd1});
        push_item('{cycles_elapsed: 8'd1,   lcd_on: 1'b1, compare_line: 8'd1});
        // display off long enough for the cycle count to saturate
        repeat (9) push_item('{cycles_elapsed: 8'hFF, lcd_on: 1'b0, compare_line: 8'hAA});
        push_item('{cycles_elapsed: 8'd0,   lcd_on: 1'b1, compare_line: 8'd2});
        push_item('{cycles_elapsed: 8'hFF,  lcd_on: 1'b1, compare_line: 8'h80});
        push_item('{cycles_elapsed: 8'hFF,  lcd_on: 1'b1, compare_line: 8'h7F});
        run_items(80);
        drain();

        // every threshold zero: each item ends its mode or, in vblank, its line
        program_timings('0, '0, '0, '0);
        run_items(300);
        drain();

        program_timings('1, '1, '1, '1);
        run_items(100);
        drain();

        program_timings(10'($urandom_range(1, 40)), 10'($urandom_range(1, 40)),
                        10'($urandom_range(1, 40)), 10'($urandom_range(1, 40)));
        run_items(400);
        drain();

        program_timings(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                        10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        run_items(200);
        drain();

        program_timings(10'd1, '1, '0, 10'd1);
        run_items(200);
        drain();

        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
